### hdl/smrfb_pkg.sv
package smrfb_pkg;

    localparam int unsigned BUS_COUNT_DEF = 4;

    localparam logic [2:0] K_SERVO_ON  = 3'd0;
    localparam logic [2:0] K_SERVO_OFF = 3'd1;
    localparam logic [2:0] K_STOP      = 3'd2;
    localparam logic [2:0] K_TRIGGER   = 3'd3;
    localparam logic [2:0] K_POSITION  = 3'd4;
    localparam logic [2:0] K_QUERY_POS = 3'd5;
    localparam logic [2:0] K_QUERY_ERR = 3'd6;
    localparam logic [2:0] K_UNUSED    = 3'd7;

    localparam logic [0:0] CFG_LOWER_LIMIT = 1'b0;
    localparam logic [0:0] CFG_UPPER_LIMIT = 1'b1;

    localparam logic [31:0] LOWER_LIMIT_RST = 32'h8000_0000;
    localparam logic [31:0] UPPER_LIMIT_RST = 32'h7FFF_FFFF;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;

    localparam logic [7:0] REG_SERVO_HI     = 8'h03;
    localparam logic [7:0] REG_SERVO_LO     = 8'h03;
    localparam logic [7:0] REG_MOTION_HI    = 8'h03;
    localparam logic [7:0] REG_MOTION_LO    = 8'h05;
    localparam logic [7:0] REG_POS_HI       = 8'h11;
    localparam logic [7:0] REG_POS_LO       = 8'h0C;
    localparam logic [7:0] REG_QUERY_HI     = 8'h0B;
    localparam logic [7:0] REG_QPOS_LO      = 8'h07;
    localparam logic [7:0] REG_QERR_LO      = 8'h15;

    typedef struct packed {
        logic       clear;
        logic       en;
        logic [7:0] data;
    } t_crc_ctl;

    function automatic logic [3:0] frame_len(input logic [2:0] kind);
        logic [3:0] n;
        case (kind)
            K_STOP, K_TRIGGER: n = 4'd9;
            K_POSITION:        n = 4'd11;
            default:           n = 4'd6;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] frame_byte(
        input logic [2:0]  kind,
        input logic [7:0]  slave,
        input logic [31:0] pos,
        input logic [3:0]  idx
    );
        logic [7:0] b;
        b = 8'h00;
        if (idx == 4'd0) begin
            b = slave;
        end else begin
            case (kind)
                K_SERVO_ON, K_SERVO_OFF: begin
                    case (idx)
                        4'd1:    b = FC_WRITE_SINGLE;
                        4'd2:    b = REG_SERVO_HI;
                        4'd3:    b = REG_SERVO_LO;
                        4'd5:    b = (kind == K_SERVO_ON) ? 8'h01 : 8'h00;
                        default: b = 8'h00;
                    endcase
                end
                K_STOP, K_TRIGGER: begin
                    case (idx)
                        4'd1:    b = FC_WRITE_MULTI;
                        4'd2:    b = REG_MOTION_HI;
                        4'd3:    b = REG_MOTION_LO;
                        4'd5:    b = 8'h01;
                        4'd6:    b = 8'h02;
                        4'd8:    b = (kind == K_TRIGGER) ? 8'h01 : 8'h00;
                        default: b = 8'h00;
                    endcase
                end
                K_POSITION: begin
                    case (idx)
                        4'd1:    b = FC_WRITE_MULTI;
                        4'd2:    b = REG_POS_HI;
                        4'd3:    b = REG_POS_LO;
                        4'd5:    b = 8'h02;
                        4'd6:    b = 8'h04;
                        4'd7:    b = pos[15:8];
                        4'd8:    b = pos[7:0];
                        4'd9:    b = pos[31:24];
                        4'd10:   b = pos[23:16];
                        default: b = 8'h00;
                    endcase
                end
                default: begin
                    case (idx)
                        4'd1:    b = FC_READ_HOLDING;
                        4'd2:    b = REG_QUERY_HI;
                        4'd3:    b = (kind == K_QUERY_POS) ? REG_QPOS_LO : REG_QERR_LO;
                        4'd5:    b = 8'h02;
                        default: b = 8'h00;
                    endcase
                end
            endcase
        end
        return b;
    endfunction

endpackage

### hdl/smrfb_crc.sv
module smrfb_crc (
    input  logic                 i_clk,
    input  smrfb_pkg::t_crc_ctl  i_ctl,
    output logic [15:0]          o_crc
);
    import smrfb_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        logic [15:0] c;
        c = r_crc ^ {8'h00, i_ctl.data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        n_crc = c;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.en) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

### hdl/smrfb_seq.sv
module smrfb_seq #(
    parameter int unsigned BUS_COUNT = smrfb_pkg::BUS_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_kind,
    input  logic [7:0]          i_bus_index,
    input  logic [7:0]          i_slave_address,
    input  logic signed [31:0]  i_position,
    input  logic signed [31:0]  i_lower_limit,
    input  logic signed [31:0]  i_upper_limit,
    output smrfb_pkg::t_crc_ctl o_crc_ctl,
    input  logic [15:0]         i_crc,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_target_bus,
    output logic [7:0]          o_frame_byte,
    output logic                o_frame_end
);
    import smrfb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_SEND  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_kind;
    logic [7:0]         r_bus;
    logic [7:0]         r_slave;
    logic signed [31:0] r_pos;
    logic [3:0]         r_idx, n_idx;
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_obyte, n_obyte;
    logic               r_oend, n_oend;
    logic [1:0]         r_obus;

    logic               in_xfer;
    logic               load;
    logic               ok;
    logic [3:0]         len;
    logic [7:0]         data_byte;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign load      = (r_state == S_SEND) && (!r_ovalid || i_out_ready);
    assign len       = frame_len(r_kind);
    assign data_byte = frame_byte(r_kind, r_slave, r_pos, r_idx);

    assign ok = ({1'b0, r_bus} < 9'(BUS_COUNT)) && (r_kind != K_UNUSED) &&
                ((r_kind != K_POSITION) ||
                 ((r_pos >= i_lower_limit) && (r_pos <= i_upper_limit)));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_out_ready;
        n_obyte  = r_obyte;
        n_oend   = r_oend;
        o_crc_ctl.clear = 1'b0;
        o_crc_ctl.en    = 1'b0;
        o_crc_ctl.data  = data_byte;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_crc_ctl.clear = 1'b1;
                n_idx   = 4'd0;
                n_state = ok ? S_SEND : S_IDLE;
            end
            S_SEND: begin
                if (load) begin
                    n_ovalid = 1'b1;
                    n_idx    = r_idx + 4'd1;
                    n_oend   = 1'b0;
                    if (r_idx < len) begin
                        n_obyte      = data_byte;
                        o_crc_ctl.en = 1'b1;
                    end else if (r_idx == len) begin
                        n_obyte = i_crc[7:0];
                    end else begin
                        n_obyte = i_crc[15:8];
                        n_oend  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind  <= i_kind;
            r_bus   <= i_bus_index;
            r_slave <= i_slave_address;
            r_pos   <= i_position;
        end
        if (load) begin
            r_obus <= r_bus[1:0];
        end
        r_idx   <= n_idx;
        r_obyte <= n_obyte;
        r_oend  <= n_oend;
    end

    assign o_out_valid  = r_ovalid;
    assign o_target_bus = r_obus;
    assign o_frame_byte = r_obyte;
    assign o_frame_end  = r_oend;

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CHECK))
        else $error("accepted item did not enter check");

    a_reject_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !ok) |=> (r_state == S_IDLE && o_in_ready))
        else $error("rejected item did not return to idle");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_idx <= 4'(len + 4'd1)))
        else $error("frame index beyond frame length");

    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_idx == 4'(len + 4'd1)) |=>
        (r_state == S_IDLE && o_out_valid && o_frame_end))
        else $error("last CRC byte not flagged as frame end");

endmodule

### hdl/servo_modbus_rtu_frame_builder.sv
// Servo command to Modbus RTU request frame builder.
// Input channel (i_in_valid / o_in_ready) takes one servo command: kind,
// bus index, slave address and position. Output channel (o_out_valid /
// i_out_ready) returns the frame one byte per transfer, with the CRC-16
// low and high bytes last; o_frame_end marks the CRC high byte.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data) sets the position
// limits: index 0 lower, index 1 upper; write only while idle.
// Flow: a command is checked in the cycle after its transfer, then, unless the
// receiver stalls, one frame byte is loaded per cycle through the single
// byte-wide CRC unit. The first byte is valid once the check state has passed
// and the send state has loaded it; an item of 8, 11 or 13 frame bytes keeps
// the input not ready from its transfer until its last byte is loaded. A
// rejected command (bus out of range, unused kind, position outside limits)
// yields no bytes and the sequencer goes from the check state back to idle.
// The last byte sits in the output register while the next command is
// taken. A stalled receiver holds the output register and pauses the
// sequencer. Reset empties the output and restores full-range limits.
module servo_modbus_rtu_frame_builder #(
    parameter int unsigned BUS_COUNT = smrfb_pkg::BUS_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_bus_index,
    input  logic [7:0]         i_slave_address,
    input  logic signed [31:0] i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_target_bus,
    output logic [7:0]         o_frame_byte,
    output logic               o_frame_end,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import smrfb_pkg::*;

    logic signed [31:0] r_lower_limit;
    logic signed [31:0] r_upper_limit;
    t_crc_ctl           crc_ctl;
    logic [15:0]        crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_limit <= LOWER_LIMIT_RST;
            r_upper_limit <= UPPER_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWER_LIMIT: r_lower_limit <= i_cfg_data;
                CFG_UPPER_LIMIT: r_upper_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    smrfb_seq #(
        .BUS_COUNT(BUS_COUNT)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_bus_index    (i_bus_index),
        .i_slave_address(i_slave_address),
        .i_position     (i_position),
        .i_lower_limit  (r_lower_limit),
        .i_upper_limit  (r_upper_limit),
        .o_crc_ctl      (crc_ctl),
        .i_crc          (crc),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_target_bus   (o_target_bus),
        .o_frame_byte   (o_frame_byte),
        .o_frame_end    (o_frame_end)
    );

    smrfb_crc u_crc (
        .i_clk(i_clk),
        .i_ctl(crc_ctl),
        .o_crc(crc)
    );

endmodule
